// ----- hw/rtl/mssr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mssr_pkg
// shared widths and stage records for the multiply-shift range reducer
// ---------------------------------------------------------------------------
package mssr_pkg;

   localparam int WORD_W     = 64;
   localparam int HALF_W     = WORD_W / 2;
   localparam int CELL_COUNT = WORD_W;   // one remainder bit per cell

   // record handed from cell to cell along the remainder chain
   typedef struct packed {
      logic              valid;
      logic              err;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] rng;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] dvd;   // dividend bits not yet consumed, msb first
   } cell_type;

endpackage

// ----- hw/rtl/mssr_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mssr_cell
// one restoring division step of the threshold remainder chain
// ---------------------------------------------------------------------------
module mssr_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  mssr_pkg::cell_type cell_in,
   output mssr_pkg::cell_type cell_out
);

   mssr_pkg::cell_type cell_ff;
   mssr_pkg::cell_type cell_next_in;
   logic [mssr_pkg::WORD_W:0] trial;
   logic [mssr_pkg::WORD_W:0] diff;

   always_comb begin
      trial = {cell_in.rem, cell_in.dvd[mssr_pkg::WORD_W-1]};
      diff  = trial - {1'b0, cell_in.rng};
      cell_next_in = cell_in;
      cell_next_in.dvd = {cell_in.dvd[mssr_pkg::WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, cell_in.rng}) begin
         cell_next_in.rem = diff[mssr_pkg::WORD_W-1:0];
      end else begin
         cell_next_in.rem = trial[mssr_pkg::WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff.valid <= cell_next_in.valid;
      end
      if (enable) begin
         cell_ff.err  <= cell_next_in.err;
         cell_ff.word <= cell_next_in.word;
         cell_ff.rng  <= cell_next_in.rng;
         cell_ff.rem  <= cell_next_in.rem;
         cell_ff.dvd  <= cell_next_in.dvd;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- hw/rtl/mssr_mul.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mssr_mul
// three-stage 64x64 product, threshold compare and result register
// ---------------------------------------------------------------------------
module mssr_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  mssr_pkg::cell_type           cell_in,
   output logic                        out_valid,
   output logic [mssr_pkg::WORD_W-1:0] out_value,
   output logic                        out_accepted,
   output logic                        out_range_error
);

   localparam int W = mssr_pkg::WORD_W;
   localparam int H = mssr_pkg::HALF_W;

   // stage a: partial products
   logic         a_valid_ff, a_err_ff;
   logic [W-1:0] a_thr_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   // stage b: column sums
   logic         b_valid_ff, b_err_ff;
   logic [W-1:0] b_thr_ff, b_hi_ff;
   logic [H+1:0] b_mid_ff;
   logic [H-1:0] b_lo_ff;
   // stage c: result
   logic         c_valid_ff, c_acc_ff, c_err_ff;
   logic [W-1:0] c_value_ff;

   logic [H+1:0] mid_in;
   logic [W-1:0] hi_in, lo_in, hi_full_in;

   always_comb begin
      mid_in = {2'b00, p00_ff[W-1:H]} + {2'b00, p01_ff[H-1:0]} + {2'b00, p10_ff[H-1:0]};
      hi_in  = p11_ff + {{H{1'b0}}, p01_ff[W-1:H]} + {{H{1'b0}}, p10_ff[W-1:H]};
      lo_in      = {b_mid_ff[H-1:0], b_lo_ff};
      hi_full_in = b_hi_ff + {{(W-2){1'b0}}, b_mid_ff[H+1:H]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= cell_in.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      if (enable) begin
         a_err_ff <= cell_in.err;
         a_thr_ff <= cell_in.rem;
         p00_ff <= W'(cell_in.word[H-1:0] * cell_in.rng[H-1:0]);
         p01_ff <= W'(cell_in.word[H-1:0] * cell_in.rng[W-1:H]);
         p10_ff <= W'(cell_in.word[W-1:H] * cell_in.rng[H-1:0]);
         p11_ff <= W'(cell_in.word[W-1:H] * cell_in.rng[W-1:H]);

         b_err_ff <= a_err_ff;
         b_thr_ff <= a_thr_ff;
         b_mid_ff <= mid_in;
         b_hi_ff  <= hi_in;
         b_lo_ff  <= p00_ff[H-1:0];

         c_err_ff   <= b_err_ff;
         c_acc_ff   <= !b_err_ff && (lo_in >= b_thr_ff);
         c_value_ff <= (!b_err_ff && (lo_in >= b_thr_ff)) ? hi_full_in : '0;
      end
   end

   assign out_valid       = c_valid_ff;
   assign out_value       = c_value_ff;
   assign out_accepted    = c_acc_ff;
   assign out_range_error = c_err_ff;

endmodule

// ----- hw/rtl/multiply_shift_range_reduce.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiply_shift_range_reduce
// unbiased reduction of a 64-bit random word into [0, range)
// ---------------------------------------------------------------------------
// Every item gives exactly one result once it has passed the whole pipeline: a chain of
// 64 cells computes the rejection threshold (2^64 - range) mod range, one
// remainder bit per cell, then a three-stage multiplier forms word * range and
// compares its low half with the threshold. One item enters per cycle; the
// whole pipeline holds only while a result sits on the output and rsp_ready
// is low. A rejected word returns accepted = 0 and value = 0; a zero range
// returns range_error = 1 with value and accepted at 0.
// ---------------------------------------------------------------------------
module multiply_shift_range_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mssr_pkg::WORD_W-1:0] req_random_word,
   input  logic [mssr_pkg::WORD_W-1:0] req_range,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mssr_pkg::WORD_W-1:0] rsp_value,
   output logic                        rsp_accepted,
   output logic                        rsp_range_error
);

   // global advance: the output slot is empty or being emptied
   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   mssr_pkg::cell_type chain [mssr_pkg::CELL_COUNT+1];

   // head of the chain: dividend is 2^64 - range, taken mod 2^64
   always_comb begin
      chain[0].valid = req_valid;
      chain[0].err   = (req_range == '0);
      chain[0].word  = req_random_word;
      chain[0].rng   = req_range;
      chain[0].rem   = '0;
      chain[0].dvd   = '0 - req_range;
   end

   // remainder chain, one division step per cell
   for (genvar i = 0; i < mssr_pkg::CELL_COUNT; i++) begin : g_cell
      mssr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .cell_in (chain[i]),
         .cell_out(chain[i+1])
      );
   end

   // product, compare and output register
   mssr_mul u_mul (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .cell_in        (chain[mssr_pkg::CELL_COUNT]),
      .out_valid      (rsp_valid),
      .out_value      (rsp_value),
      .out_accepted   (rsp_accepted),
      .out_range_error(rsp_range_error)
   );

endmodule

// ----- hw/rtl/mssr_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mssr_checker
// port-level checks of the range reducer, bound to the top level
// ---------------------------------------------------------------------------
module mssr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mssr_pkg::WORD_W-1:0] rsp_value,
   input logic                        rsp_accepted,
   input logic                        rsp_range_error
);

   // zero range leaves value and accepted clear
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> !rsp_accepted && rsp_value == '0)
      else $error("range error item carries data");

   // rejected item shows value zero
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_value == '0)
      else $error("rejected item has nonzero value");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_accepted) && $stable(rsp_range_error))
      else $error("stalled result changed");

   // input is taken whenever the output slot is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with free output");

endmodule

bind multiply_shift_range_reduce mssr_checker u_mssr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_value      (rsp_value),
   .rsp_accepted   (rsp_accepted),
   .rsp_range_error(rsp_range_error)
);

// ----- sim/multiply_shift_range_reduce_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiply_shift_range_reduce_test
// self-checking bench for the multiply-shift range reducer: a queue-fed
// driver and a monitor with random gaps on both sides, checked in order
// against a behavioral predictor of the threshold and the 128-bit product
// ---------------------------------------------------------------------------
module multiply_shift_range_reduce_test;

   localparam int WORD_W = mssr_pkg::WORD_W;

   // one stimulus item and one predicted result
   typedef struct {
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] rng;
   } draw_item_type;

   typedef struct {
      logic [WORD_W-1:0] value;
      logic              accepted;
      logic              range_error;
   } draw_result_type;

   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_LIMIT   = 2000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 80;     // pipeline depth plus margin
   localparam int HOLD_CYCLES  = 200;    // long receiver hold-off

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [WORD_W-1:0] req_random_word;
   logic [WORD_W-1:0] req_range;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_value;
   logic              rsp_accepted;
   logic              rsp_range_error;

   draw_item_type   pending_draws[$];
   draw_result_type expected_draws[$];
   bit              stimulus_done;
   int              error_count = 0;
   int              idle_cycles = 0;
   int              send_gap;
   int              recv_gap;
   int              hold_count;
   int              received_count;

   multiply_shift_range_reduce u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_random_word (req_random_word),
      .req_range       (req_range),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_accepted    (rsp_accepted),
      .rsp_range_error (rsp_range_error)
   );

   // predictor: threshold is (2^64 - range) mod range, value is the high half
   function automatic draw_result_type reduce_draw(draw_item_type it);
      draw_result_type     r;
      logic [2*WORD_W-1:0] prod;
      logic [WORD_W-1:0]   thresh;
      r = '{value: '0, accepted: 1'b0, range_error: 1'b0};
      if (it.rng == '0) begin
         r.range_error = 1'b1;
         return r;
      end
      prod   = {{WORD_W{1'b0}}, it.word} * {{WORD_W{1'b0}}, it.rng};
      thresh = (~it.rng + 1'b1) % it.rng;
      if (prod[WORD_W-1:0] >= thresh) begin
         r.value    = prod[2*WORD_W-1:WORD_W];
         r.accepted = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // ranges: a mix of random, wide and tiny values, some just above half that reject often
   function automatic logic [WORD_W-1:0] rand_range();
      logic [WORD_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = rand_word();
         1: v = {1'b1, 63'd0} + {32'd0, $urandom};
         2: v = 64'($urandom_range(0, 16));
         3: v = rand_word() >> $urandom_range(0, 63);
         4: v = {WORD_W{1'b1}} - 64'($urandom_range(0, 8));
         default: v = ({1'b1, 63'd0} >> $urandom_range(0, 63))
                      + 64'($urandom_range(0, 3));
      endcase
      return v;
   endfunction

   task automatic push_draw(logic [WORD_W-1:0] w, logic [WORD_W-1:0] r);
      pending_draws.push_back('{word: w, rng: r});
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // reset once, then queue directed and random items
   initial begin
      reset = 1'b1;
      stimulus_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // zero range, with extreme and random words
      push_draw('0, '0);
      push_draw({WORD_W{1'b1}}, '0);
      push_draw(rand_word(), '0);
      // range of one: always accepted with value zero
      push_draw('0, 64'd1);
      push_draw({WORD_W{1'b1}}, 64'd1);
      // largest range, threshold one: word zero is rejected
      push_draw('0, {WORD_W{1'b1}});
      push_draw(64'd1, {WORD_W{1'b1}});
      push_draw({WORD_W{1'b1}}, {WORD_W{1'b1}});
      // range just above half: high threshold, many rejects
      push_draw('0, {1'b1, 62'd0, 1'b1});
      push_draw(64'h7FFF_FFFF_FFFF_FFFF, {1'b1, 62'd0, 1'b1});
      push_draw({WORD_W{1'b1}}, {1'b1, 62'd0, 1'b1});
      // power of two ranges with threshold zero, then range three
      push_draw({WORD_W{1'b1}}, {1'b1, 63'd0});
      push_draw(64'h1234_5678_9ABC_DEF0, 64'd2);
      push_draw(64'd5, 64'd3);
      push_draw({WORD_W{1'b1}}, 64'd3);
      repeat (RANDOM_ITEMS) push_draw(rand_word(), rand_range());
      stimulus_done = 1'b1;
   end

   // driver: random gap before each item, valid held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_random_word <= '0;
         req_range       <= '0;
         send_gap        <= $urandom_range(0, 3);
      end else if (req_valid && !req_ready) begin
         // holding the offered item
      end else if (send_gap > 0) begin
         if (req_valid) expected_draws.push_back(reduce_draw('{req_random_word, req_range}));
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else begin
         if (req_valid) begin
            expected_draws.push_back(reduce_draw('{req_random_word, req_range}));
            send_gap <= $urandom_range(0, 3);
         end
         if (pending_draws.size() > 0) begin
            draw_item_type it;
            it = pending_draws.pop_front();
            req_valid       <= 1'b1;
            req_random_word <= it.word;
            req_range       <= it.rng;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compares each result with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         recv_gap       <= $urandom_range(0, 3);
         hold_count     <= 0;
         received_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received_count <= received_count + 1;
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected result value=%h accepted=%b range_error=%b",
                        $time, rsp_value, rsp_accepted, rsp_range_error);
               error_count++;
            end else begin
               draw_result_type e;
               e = expected_draws.pop_front();
               if (rsp_value !== e.value) begin
                  $display("%0t: value expected %h actual %h", $time, e.value, rsp_value);
                  error_count++;
               end
               if (rsp_accepted !== e.accepted) begin
                  $display("%0t: accepted expected %b actual %b",
                           $time, e.accepted, rsp_accepted);
                  error_count++;
               end
               if (rsp_range_error !== e.range_error) begin
                  $display("%0t: range_error expected %b actual %b",
                           $time, e.range_error, rsp_range_error);
                  error_count++;
               end
            end
         end
         // one long hold-off after a few hundred results to fill the pipeline
         if (received_count >= 300 && hold_count < HOLD_CYCLES) begin
            rsp_ready  <= 1'b0;
            hold_count <= hold_count + 1;
         end else if (rsp_ready && !rsp_valid) begin
            // keep ready until a result is taken
         end else if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready) recv_gap <= $urandom_range(0, 3);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multiply_shift_range_reduce_test: errors");
         $finish;
      end
   end

   // end of run: all items sent and accepted, predictions drained
   initial begin
      wait (stimulus_done);
      @(posedge clock);
      while (pending_draws.size() > 0 || req_valid || expected_draws.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_draws.size() == 0)
         $display("multiply_shift_range_reduce_test: clean");
      else
         $display("multiply_shift_range_reduce_test: errors");
      $finish;
   end

endmodule

// ----- multiply_shift_range_reduce.f -----
hw/rtl/mssr_pkg.sv
hw/rtl/mssr_cell.sv
hw/rtl/mssr_mul.sv
hw/rtl/multiply_shift_range_reduce.sv
hw/rtl/mssr_checker.sv
sim/multiply_shift_range_reduce_test.sv
